// File: design/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

  localparam int CHAR_W = 8;
  localparam int ADDR_W = 11;
  localparam int DATA_W = 16;
  localparam int COL_OUT_W = 7;
  localparam int ROW_OUT_W = 5;

  localparam logic OP_PUT = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
  // Attribute is never changed by any item, so every cell carries this one.
  localparam logic [CHAR_W-1:0] ATTR_BYTE = 8'h07;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_e;

  typedef struct packed {
    logic accept;      // input item taken this cycle
    logic clear_step;  // write one blank cell of the sweep
  } tcw_cmd_t;

  typedef struct packed {
    logic clear_last;  // sweep is at the last cell
    logic blank;       // the offered item, if a put, wraps past the last row
  } tcw_sts_t;

endpackage

`default_nettype wire

// File: design/tcw_ctrl.sv
`default_nettype none

module tcw_ctrl
  import tcw_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     s_valid_i,
  output logic          s_ready_o,
  output logic          m_valid_o,
  input  wire logic     m_ready_i,
  input  wire tcw_sts_t sts_i,
  output tcw_cmd_t      cmd_o
);

  state_e st_q, st_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || m_ready_i;
  assign s_ready_o = (st_q == ST_RUN) && slot_free;
  assign m_valid_o = out_valid_q;

  assign cmd_o.accept     = s_ready_o && s_valid_i;
  assign cmd_o.clear_step = (st_q == ST_CLEAR);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_CLEAR: begin
        if (sts_i.clear_last) st_d = ST_RUN;
      end
      ST_RUN: begin
        if (cmd_o.accept && sts_i.blank) st_d = ST_CLEAR;
      end
      default: st_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.accept) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_CLEAR |-> !cmd_o.accept)
    else $error("item accepted during clear sweep");

  a_blank_starts_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept && sts_i.blank |=> st_q == ST_CLEAR)
    else $error("screen blank did not start a sweep");

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> m_valid_o)
    else $error("accepted item produced no result");

endmodule

`default_nettype wire

// File: design/tcw_dp.sv
`default_nettype none

module tcw_dp
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tcw_cmd_t          cmd_i,
  output tcw_sts_t               sts_o,
  input  wire logic              opcode_i,
  input  wire logic [CHAR_W-1:0] char_code_i,
  input  wire logic [ADDR_W-1:0] cell_address_i,
  output logic [DATA_W-1:0]      read_data_o,
  output logic [COL_OUT_W-1:0]   cursor_column_o,
  output logic [ROW_OUT_W-1:0]   cursor_row_o,
  output logic                   screen_cleared_o
);

  localparam int Cells = COLUMNS * ROWS;
  localparam int AW = $clog2(Cells);
  localparam int CW = $clog2(COLUMNS);
  localparam int RW = $clog2(ROWS);

  // Character bytes only; the attribute is constant.
  logic [CHAR_W-1:0] mem [Cells];
  logic [CHAR_W-1:0] rd_q;

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic          cleared_q, cleared_d;
  logic [AW-1:0] clr_cnt_q;
  logic          op_q;
  logic          in_range_q;

  logic          is_put, is_nl, col_last, row_last, wrap, in_range;
  logic [AW-1:0] put_idx, rd_idx;

  assign is_put   = cmd_i.accept && (opcode_i == OP_PUT);
  assign is_nl    = (char_code_i == NEWLINE_CHAR);
  assign col_last = (col_q == CW'(COLUMNS - 1));
  assign row_last = (row_q == RW'(ROWS - 1));
  assign wrap     = is_nl || col_last;
  assign in_range = int'(cell_address_i) < Cells;
  assign put_idx  = AW'(int'(row_q) * COLUMNS + int'(col_q));
  assign rd_idx   = AW'(cell_address_i);

  assign sts_o.blank      = (opcode_i == OP_PUT) && wrap && row_last;
  assign sts_o.clear_last = (clr_cnt_q == AW'(Cells - 1));

  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    cleared_d = cleared_q;
    if (cmd_i.accept) begin
      cleared_d = 1'b0;
      if (is_put) begin
        if (wrap) begin
          col_d = '0;
          if (row_last) begin
            row_d     = '0;
            cleared_d = 1'b1;
          end else begin
            row_d = row_q + RW'(1);
          end
        end else begin
          col_d = col_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      cleared_q <= 1'b0;
      clr_cnt_q <= '0;
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      cleared_q <= cleared_d;
      if (cmd_i.clear_step) begin
        clr_cnt_q <= sts_o.clear_last ? '0 : clr_cnt_q + AW'(1);
      end
    end
  end

  // Sweep and puts never overlap: no item is taken during a sweep.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_step) begin
      mem[clr_cnt_q] <= BLANK_CHAR;
    end else if (is_put && !is_nl) begin
      mem[put_idx] <= char_code_i;
    end
    if (cmd_i.accept && (opcode_i == OP_READ)) begin
      rd_q <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q       <= opcode_i;
      in_range_q <= in_range;
    end
  end

  // Cursor registers only move on accept, so they hold the last item's view.
  assign read_data_o      = (op_q == OP_READ && in_range_q) ? {ATTR_BYTE, rd_q} : '0;
  assign cursor_column_o  = COL_OUT_W'(col_q);
  assign cursor_row_o     = ROW_OUT_W'(row_q);
  assign screen_cleared_o = cleared_q;

  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(col_q) < COLUMNS && int'(row_q) < ROWS)
    else $error("cursor outside the screen");

endmodule

`default_nettype wire

// File: design/text_console_writer.sv
// Text console: COLUMNS x ROWS character cells, attribute 0x07 in the high
// byte of each 16-bit cell, character in the low byte.
// Input channel s_axis: tuser is the opcode (put / read), tdata carries the
// character byte and the cell address used by reads.
// Output channel m_axis: exactly one result item per input item: the cell
// read (0 for a put), the cursor after the item and the screen-blank flag.
// The result is valid in the cycle after input accept. Puts and reads run
// at one item per cycle while no sweep runs and the output slot is free:
// a put is one write of the character store, a read one registered read.
// A put that moves past the last row blanks the screen: the result is
// returned at once, then a sweep writes one cell per cycle over all
// COLUMNS*ROWS cells (2000 by default) with s_axis_tready low.
// After reset the same sweep runs once to fill the store with blanks
// before the first item is taken; the cursor is homed.
// The result waits in an output register while m_axis_tready is low; one
// new item is still taken in the cycle the waiting result is consumed.
`default_nettype none

module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // char_code[7:0], cell_address[18:8], zero pad
  input  wire logic        s_axis_tuser,  // opcode[0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata   // read_data[15:0], cursor_column[22:16],
                                          // cursor_row[27:23], screen_cleared[28], zero pad
);

  tcw_cmd_t              cmd;
  tcw_sts_t              sts;
  logic [DATA_W-1:0]     read_data;
  logic [COL_OUT_W-1:0]  cursor_column;
  logic [ROW_OUT_W-1:0]  cursor_row;
  logic                  screen_cleared;

  tcw_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  tcw_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .opcode_i         (s_axis_tuser),
    .char_code_i      (s_axis_tdata[7:0]),
    .cell_address_i   (s_axis_tdata[18:8]),
    .read_data_o      (read_data),
    .cursor_column_o  (cursor_column),
    .cursor_row_o     (cursor_row),
    .screen_cleared_o (screen_cleared)
  );

  assign m_axis_tdata = {3'b000, screen_cleared, cursor_row, cursor_column, read_data};

endmodule

`default_nettype wire

// File: tb/text_console_checker.sv
`timescale 1ns / 1ps

module text_console_checker
  import tcw_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // char_code[7:0], cell_address[18:8], zero pad
  input  wire logic        s_axis_tuser,  // opcode[0]
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [31:0] m_axis_tdata,  // read_data[15:0], cursor_column[22:16],
                                          // cursor_row[27:23], screen_cleared[28], zero pad
  output int               fail_count_o,
  output int               pending_o
);

  localparam int COLUMNS = 80;
  localparam int ROWS = 25;
  localparam int CELLS = COLUMNS * ROWS;
  localparam int REPORT_LIMIT = 10;

  // read_data ends up in the low bits, matching m_axis_tdata[28:0]
  typedef struct packed {
    logic                 screen_cleared;
    logic [ROW_OUT_W-1:0] cursor_row;
    logic [COL_OUT_W-1:0] cursor_column;
    logic [DATA_W-1:0]    read_data;
  } console_result_t;

  logic [DATA_W-1:0] screen_mem [CELLS];
  int unsigned       cursor_col;
  int unsigned       cursor_row;
  console_result_t   predicted_results[$];
  int                mismatch_count = 0;

  // Applies one item to the shadow screen and cursor, returns the result it causes.
  function automatic console_result_t advance_console(input logic op,
                                                      input logic [CHAR_W-1:0] ch,
                                                      input logic [ADDR_W-1:0] addr);
    console_result_t res;
    int unsigned col;
    int unsigned row;
    res = '0;
    col = cursor_col;
    row = cursor_row;
    if (op == OP_READ) begin
      if (addr < CELLS) res.read_data = screen_mem[addr];
    end else begin
      if (ch == NEWLINE_CHAR) begin
        col = 0;
        row++;
      end else begin
        screen_mem[row * COLUMNS + col][CHAR_W-1:0] = ch;
        col++;
      end
      if (col >= COLUMNS) begin
        col = 0;
        row++;
      end
      if (row >= ROWS) begin
        // blank characters only, attributes stay
        foreach (screen_mem[i]) screen_mem[i][CHAR_W-1:0] = BLANK_CHAR;
        col = 0;
        row = 0;
        res.screen_cleared = 1'b1;
      end
    end
    cursor_col = col;
    cursor_row = row;
    res.cursor_column = col[COL_OUT_W-1:0];
    res.cursor_row = row[ROW_OUT_W-1:0];
    return res;
  endfunction

  task automatic log_failure(input string what, input console_result_t exp_r,
                             input console_result_t act_r);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("%0t: %s: expected data=%h col=%0d row=%0d clr=%b, got data=%h col=%0d row=%0d clr=%b",
               $realtime, what, exp_r.read_data, exp_r.cursor_column, exp_r.cursor_row,
               exp_r.screen_cleared, act_r.read_data, act_r.cursor_column, act_r.cursor_row,
               act_r.screen_cleared);
  endtask

  always @(posedge clk_i) begin
    console_result_t exp_r;
    console_result_t act_r;
    if (!rst_ni) begin
      foreach (screen_mem[i]) screen_mem[i] = {ATTR_BYTE, BLANK_CHAR};
      cursor_col = 0;
      cursor_row = 0;
      predicted_results.delete();
    end else begin
      // results leave in a later cycle than their item, so drain before adding
      if (m_axis_tvalid && m_axis_tready) begin
        act_r = m_axis_tdata[28:0];
        if (predicted_results.size() == 0) begin
          log_failure("result without a pending item", '0, act_r);
        end else begin
          exp_r = predicted_results.pop_front();
          if (exp_r.read_data !== act_r.read_data ||
              exp_r.cursor_column !== act_r.cursor_column ||
              exp_r.cursor_row !== act_r.cursor_row ||
              exp_r.screen_cleared !== act_r.screen_cleared)
            log_failure("result mismatch", exp_r, act_r);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        predicted_results.push_back(advance_console(s_axis_tuser, s_axis_tdata[7:0],
                                                    s_axis_tdata[18:8]));
    end
    fail_count_o <= mismatch_count;
    pending_o <= predicted_results.size();
  end

endmodule

// File: tb/text_console_writer_test.sv
`timescale 1ns / 1ps

module text_console_writer_test
  import tcw_pkg::*;
();

  localparam int CELLS = 80 * 25;
  localparam int RANDOM_ITEMS = 850;
  localparam int CYCLE_LIMIT = 600000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tuser = OP_PUT;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  int fail_count;
  int pending_count;
  int send_idle_pct = 32;
  int recv_stall_pct = 64;
  int cycle_count = 0;
  int line_left = 0;

  text_console_writer uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  text_console_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_item(input logic op, input logic [CHAR_W-1:0] ch,
                           input logic [ADDR_W-1:0] addr);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'b0, addr, ch};
    s_axis_tuser <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Mostly lines of text ended by newlines: many empty lines so the screen
  // blanks past the last row, a few long ones to wrap columns, reads mixed in.
  task automatic random_item();
    logic [ADDR_W-1:0] addr;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 28) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) addr = ADDR_W'($urandom_range(0, 4 * 80 - 1));
      else if (pick < 80) addr = ADDR_W'($urandom_range(0, CELLS - 1));
      else addr = ADDR_W'($urandom_range(CELLS - 24, 2047));
      send_item(OP_READ, CHAR_W'($urandom_range(0, 255)), addr);
    end else if (pick < 32) begin
      send_item(OP_PUT, CHAR_W'($urandom_range(0, 255)), ADDR_W'($urandom_range(0, 2047)));
    end else if (line_left == 0) begin
      send_item(OP_PUT, NEWLINE_CHAR, ADDR_W'($urandom_range(0, 2047)));
      pick = $urandom_range(0, 99);
      if (pick < 78) line_left = 0;
      else if (pick < 89) line_left = $urandom_range(1, 8);
      else if (pick < 95) line_left = $urandom_range(9, 79);
      else line_left = $urandom_range(80, 170);
    end else begin
      send_item(OP_PUT, CHAR_W'($urandom_range(0, 255)), ADDR_W'($urandom_range(0, 2047)));
      line_left--;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset contents, last cell, out-of-range addresses
    send_item(OP_READ, 8'h00, 11'd0);
    send_item(OP_READ, 8'hFF, 11'd1999);
    send_item(OP_READ, 8'h00, 11'd2000);
    send_item(OP_READ, 8'hFF, 11'd2047);
    // zero byte and high bytes are plain characters
    send_item(OP_PUT, 8'h00, 11'd0);
    send_item(OP_PUT, 8'hFF, 11'h7FF);
    send_item(OP_PUT, 8'h80, 11'h2AA);
    send_item(OP_PUT, 8'h7F, 11'h555);
    send_item(OP_PUT, 8'h41, 11'd0);
    send_item(OP_READ, 8'h00, 11'd0);
    send_item(OP_READ, 8'h00, 11'd1);
    send_item(OP_READ, 8'h00, 11'd2);
    send_item(OP_READ, 8'h00, 11'd3);
    send_item(OP_READ, 8'h00, 11'd4);
    send_item(OP_READ, 8'h00, 11'd5);
    send_item(OP_PUT, NEWLINE_CHAR, 11'd0);
    send_item(OP_PUT, 8'h20, 11'd0);
    send_item(OP_PUT, 8'h55, 11'd0);
    send_item(OP_READ, 8'h00, 11'd80);
    send_item(OP_READ, 8'h00, 11'd81);
    send_item(OP_READ, 8'h55, 11'h2AA);
    send_item(OP_READ, 8'hAA, 11'h555);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        send_idle_pct = 64;
        recv_stall_pct = 32;
      end else if (i == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      random_item();
    end
    s_axis_tvalid <= 1'b0;

    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
